FILE: design/cppc_pkg.sv
// Shared types, constants and fixed-point helpers for the Cartesian pose PID.
// Used by cppc_ctrl, cppc_datapath and cartesian_pose_pid_controller.
`default_nettype none
package cppc_pkg;

  localparam int FRAC = 16;
  localparam int DW   = 32;
  localparam int PW   = 50;   // product after the Q shift
  localparam int AW   = 56;   // accumulator width
  localparam int NCFG = 8;

  localparam logic [30:0] SUM_LIMIT_LINEAR  = 31'd6553600;
  localparam logic [30:0] SUM_LIMIT_ANGULAR = 31'd6553600;

  localparam logic [2:0] CFG_KP_LIN  = 3'd0;
  localparam logic [2:0] CFG_KI_LIN  = 3'd1;
  localparam logic [2:0] CFG_KD_LIN  = 3'd2;
  localparam logic [2:0] CFG_KP_ANG  = 3'd3;
  localparam logic [2:0] CFG_KI_ANG  = 3'd4;
  localparam logic [2:0] CFG_KD_ANG  = 3'd5;
  localparam logic [2:0] CFG_LIM_LIN = 3'd6;
  localparam logic [2:0] CFG_LIM_ANG = 3'd7;

  typedef enum logic [1:0] {
    OP_TARGET   = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_ABORT    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MS_QUAT  = 2'd0,
    MS_CROSS = 2'd1,
    MS_GAIN  = 2'd2
  } msrc_t;

  typedef struct packed {
    logic       capture;
    logic       abort;
    logic       mul_en;
    msrc_t      msrc;
    logic [3:0] qidx;
    logic       t_wr;
    logic       rot_wr;
    logic       to_goal;
    logic       acc_clr;
    logic [1:0] col;
    logic [1:0] comp;
    logic       term;
    logic       x_acc;
    logic       err_wr;
    logic [2:0] axis;
    logic [1:0] gterm;
    logic       ax_set;
    logic       g_acc;
    logic       vel_wr;
    logic       out_wr;
  } cppc_cmd_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(64'sd2147483647);
    lo = -AW'(64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[DW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] clampsym(input logic signed [AW-1:0] v,
                                                    input logic [30:0] lim);
    logic signed [AW-1:0] l;
    l = $signed({{(AW-31){1'b0}}, lim});
    if (v > l) return l;
    else if (v < -l) return -l;
    else return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/cppc_datapath.sv
// Datapath: pose store, shared 33x33 multiplier, accumulators, PID state, outputs.
// Depends on cppc_pkg; driven by cppc_ctrl through cppc_cmd_t.
`default_nettype none
module cppc_datapath
  import cppc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cppc_cmd_t            cmd,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   quat_x,
  input  logic signed [31:0]   quat_y,
  input  logic signed [31:0]   quat_z,
  input  logic signed [31:0]   quat_w,
  input  logic                 cfg_wr,
  input  logic [3:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  output logic signed [31:0]   vel_x,
  output logic signed [31:0]   vel_y,
  output logic signed [31:0]   vel_z,
  output logic signed [31:0]   rate_x,
  output logic signed [31:0]   rate_y,
  output logic signed [31:0]   rate_z
);

  localparam logic signed [DW-1:0] ONE = DW'(1 << FRAC);

  logic [30:0]            cfg [NCFG];
  logic signed [DW-1:0]   lp [3];
  logic signed [DW-1:0]   lq [4];
  logic signed [DW-1:0]   gp [3];
  logic signed [DW-1:0]   mp [3];
  logic signed [DW-1:0]   gr [9];
  logic signed [DW-1:0]   mr [9];
  logic signed [PW-1:0]   t [9];
  logic signed [AW-1:0]   xs [3];
  logic signed [DW-1:0]   e [6];
  logic signed [DW-1:0]   esum [6];
  logic signed [DW-1:0]   prev [6];
  logic signed [DW-1:0]   vel [6];
  logic signed [DW-1:0]   vout [6];
  logic signed [DW:0]     dreg;
  logic signed [AW-1:0]   vacc;
  logic signed [65:0]     prod;

  logic signed [DW:0]     ma;
  logic signed [DW:0]     mb;
  logic signed [65:0]     prod_sh;
  logic signed [PW-1:0]   prodq;
  logic signed [AW-1:0]   pq;
  logic [1:0]             ra;
  logic [1:0]             rb;
  logic [3:0]             ga_idx;
  logic [3:0]             mb_idx;
  logic                   ang;
  logic [30:0]            kp;
  logic [30:0]            ki;
  logic [30:0]            kd;
  logic [30:0]            lim;
  logic [30:0]            slim;
  logic signed [DW-1:0]   rot [9];
  logic signed [AW-1:0]   tx [9];
  logic signed [AW-1:0]   nsum;

  always_comb begin
    case ({cmd.comp, cmd.term})
      3'b000:  begin ra = 2'd1; rb = 2'd2; end
      3'b001:  begin ra = 2'd2; rb = 2'd1; end
      3'b010:  begin ra = 2'd2; rb = 2'd0; end
      3'b011:  begin ra = 2'd0; rb = 2'd2; end
      3'b100:  begin ra = 2'd0; rb = 2'd1; end
      3'b101:  begin ra = 2'd1; rb = 2'd0; end
      default: begin ra = 2'd0; rb = 2'd0; end
    endcase
  end

  assign ga_idx = 4'({2'b0, ra} * 4'd3) + {2'b0, cmd.col};
  assign mb_idx = 4'({2'b0, rb} * 4'd3) + {2'b0, cmd.col};
  assign ang  = (cmd.axis > 3'd2);
  assign kp   = ang ? cfg[CFG_KP_ANG] : cfg[CFG_KP_LIN];
  assign ki   = ang ? cfg[CFG_KI_ANG] : cfg[CFG_KI_LIN];
  assign kd   = ang ? cfg[CFG_KD_ANG] : cfg[CFG_KD_LIN];
  assign lim  = ang ? cfg[CFG_LIM_ANG] : cfg[CFG_LIM_LIN];
  assign slim = ang ? SUM_LIMIT_ANGULAR : SUM_LIMIT_LINEAR;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.msrc)
      MS_QUAT: begin
        case (cmd.qidx)
          4'd0:    begin ma = 33'(lq[0]); mb = 33'(lq[0]); end
          4'd1:    begin ma = 33'(lq[1]); mb = 33'(lq[1]); end
          4'd2:    begin ma = 33'(lq[2]); mb = 33'(lq[2]); end
          4'd3:    begin ma = 33'(lq[0]); mb = 33'(lq[1]); end
          4'd4:    begin ma = 33'(lq[0]); mb = 33'(lq[2]); end
          4'd5:    begin ma = 33'(lq[1]); mb = 33'(lq[2]); end
          4'd6:    begin ma = 33'(lq[0]); mb = 33'(lq[3]); end
          4'd7:    begin ma = 33'(lq[1]); mb = 33'(lq[3]); end
          4'd8:    begin ma = 33'(lq[2]); mb = 33'(lq[3]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      MS_CROSS: begin
        ma = 33'(gr[ga_idx]);
        mb = 33'(mr[mb_idx]);
      end
      MS_GAIN: begin
        case (cmd.gterm)
          2'd0:    begin ma = 33'(e[cmd.axis]);    mb = $signed({2'b0, kp}); end
          2'd1:    begin ma = 33'(esum[cmd.axis]); mb = $signed({2'b0, ki}); end
          default: begin ma = dreg;                mb = $signed({2'b0, kd}); end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_sh = prod >>> FRAC;
  assign prodq   = prod_sh[PW-1:0];
  assign pq      = AW'(prodq);

  always_comb begin
    for (int k = 0; k < 9; k++) tx[k] = AW'(t[k]);
    rot[0] = sat32(AW'(ONE) - ((tx[1] + tx[2]) <<< 1));
    rot[1] = sat32((tx[3] - tx[8]) <<< 1);
    rot[2] = sat32((tx[4] + tx[7]) <<< 1);
    rot[3] = sat32((tx[3] + tx[8]) <<< 1);
    rot[4] = sat32(AW'(ONE) - ((tx[0] + tx[2]) <<< 1));
    rot[5] = sat32((tx[5] - tx[6]) <<< 1);
    rot[6] = sat32((tx[4] - tx[7]) <<< 1);
    rot[7] = sat32((tx[5] + tx[6]) <<< 1);
    rot[8] = sat32(AW'(ONE) - ((tx[0] + tx[1]) <<< 1));
  end

  assign nsum = clampsym(AW'(esum[cmd.axis]) + AW'(e[cmd.axis]), slim);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lp[0] <= pos_x;  lp[1] <= pos_y;  lp[2] <= pos_z;
      lq[0] <= quat_x; lq[1] <= quat_y; lq[2] <= quat_z; lq[3] <= quat_w;
    end
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.t_wr) t[cmd.qidx] <= prodq;
    if (cmd.acc_clr) begin
      for (int k = 0; k < 3; k++) xs[k] <= '0;
    end else if (cmd.x_acc) begin
      xs[cmd.comp] <= cmd.term ? xs[cmd.comp] - pq : xs[cmd.comp] + pq;
    end
    if (cmd.err_wr) begin
      for (int k = 0; k < 3; k++) begin
        e[k]     <= sat32(AW'(gp[k]) - AW'(mp[k]));
        e[3 + k] <= sat32((-xs[k]) >>> 1);
      end
    end
    if (cmd.ax_set) begin
      dreg <= 33'(e[cmd.axis]) - 33'(prev[cmd.axis]);
      vacc <= '0;
    end else if (cmd.g_acc) begin
      vacc <= vacc + pq;
    end
    if (cmd.vel_wr) vel[cmd.axis] <= DW'(clampsym(vacc, lim));
    if (cmd.out_wr) begin
      for (int k = 0; k < 6; k++) vout[k] <= vel[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[CFG_KP_LIN]  <= 31'd65536;
      cfg[CFG_KI_LIN]  <= 31'd0;
      cfg[CFG_KD_LIN]  <= 31'd983040;
      cfg[CFG_KP_ANG]  <= 31'd65536;
      cfg[CFG_KI_ANG]  <= 31'd0;
      cfg[CFG_KD_ANG]  <= 31'd983040;
      cfg[CFG_LIM_LIN] <= 31'd32768;
      cfg[CFG_LIM_ANG] <= 31'd65536;
      for (int k = 0; k < 3; k++) begin
        gp[k] <= '0;
        mp[k] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        gr[k] <= (k % 4 == 0) ? ONE : '0;
        mr[k] <= (k % 4 == 0) ? ONE : '0;
      end
      for (int k = 0; k < 6; k++) begin
        esum[k] <= '0;
        prev[k] <= '0;
      end
    end else begin
      if (cfg_wr && !cfg_index[3]) cfg[cfg_index[2:0]] <= cfg_data;
      if (cmd.rot_wr) begin
        if (cmd.to_goal) begin
          for (int k = 0; k < 3; k++) gp[k] <= lp[k];
          for (int k = 0; k < 9; k++) gr[k] <= rot[k];
        end else begin
          for (int k = 0; k < 3; k++) mp[k] <= lp[k];
          for (int k = 0; k < 9; k++) mr[k] <= rot[k];
        end
      end
      if (cmd.abort) begin
        for (int k = 0; k < 6; k++) begin
          esum[k] <= '0;
          prev[k] <= '0;
        end
      end else if (cmd.ax_set) begin
        esum[cmd.axis] <= nsum[DW-1:0];
        prev[cmd.axis] <= e[cmd.axis];
      end
    end
  end

  assign vel_x  = vout[0];
  assign vel_y  = vout[1];
  assign vel_z  = vout[2];
  assign rate_x = vout[3];
  assign rate_y = vout[4];
  assign rate_z = vout[5];

endmodule
`default_nettype wire

FILE: design/cppc_ctrl.sv
// Controller: sequences pose loads and control ticks over the shared multiplier.
// Depends on cppc_pkg; drives cppc_datapath through cppc_cmd_t.
`default_nettype none
module cppc_ctrl
  import cppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic       frame_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output cppc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_QMUL, S_QACC, S_ROTWR, S_XMUL, S_XACC, S_ERRWR,
    S_AXSET, S_GMUL, S_GACC, S_VOUT, S_PUB
  } state_t;

  state_t     state;
  op_t        opc;
  logic       goal_valid;
  logic       meas_valid;
  logic       to_goal;
  logic [3:0] qidx;
  logic [1:0] col;
  logic [1:0] comp;
  logic       term;
  logic [2:0] axis;
  logic [1:0] gterm;
  logic       accept;
  logic       out_free;

  assign opc      = op_t'(op);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.qidx    = qidx;
    cmd.col     = col;
    cmd.comp    = comp;
    cmd.term    = term;
    cmd.axis    = axis;
    cmd.gterm   = gterm;
    cmd.to_goal = to_goal;
    cmd.capture = accept && frame_ok && (opc == OP_TARGET || opc == OP_FEEDBACK);
    cmd.abort   = accept && (opc == OP_ABORT);
    cmd.acc_clr = accept && (opc == OP_TICK);
    cmd.mul_en  = (state == S_QMUL) || (state == S_XMUL) || (state == S_GMUL);
    cmd.msrc    = (state == S_XMUL) ? MS_CROSS : (state == S_GMUL) ? MS_GAIN : MS_QUAT;
    cmd.t_wr    = (state == S_QACC);
    cmd.rot_wr  = (state == S_ROTWR);
    cmd.x_acc   = (state == S_XACC);
    cmd.err_wr  = (state == S_ERRWR);
    cmd.ax_set  = (state == S_AXSET);
    cmd.g_acc   = (state == S_GACC);
    cmd.vel_wr  = (state == S_VOUT);
    cmd.out_wr  = (state == S_PUB) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      goal_valid <= 1'b0;
      meas_valid <= 1'b0;
      to_goal    <= 1'b0;
      out_valid  <= 1'b0;
      qidx       <= '0;
      col        <= '0;
      comp       <= '0;
      term       <= 1'b0;
      axis       <= '0;
      gterm      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_PUB) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qidx <= '0;
            col  <= '0;
            comp <= '0;
            term <= 1'b0;
            unique case (opc)
              OP_TARGET: begin
                if (frame_ok) begin
                  to_goal <= 1'b1;
                  state   <= S_QMUL;
                end
              end
              OP_FEEDBACK: begin
                if (frame_ok) begin
                  to_goal <= 1'b0;
                  state   <= S_QMUL;
                end else begin
                  meas_valid <= 1'b0;
                end
              end
              OP_ABORT: goal_valid <= 1'b0;
              default: begin
                if (goal_valid && meas_valid) state <= S_XMUL;
              end
            endcase
          end
        end
        S_QMUL: state <= S_QACC;
        S_QACC: begin
          if (qidx == 4'd8) begin
            state <= S_ROTWR;
          end else begin
            qidx  <= qidx + 4'd1;
            state <= S_QMUL;
          end
        end
        S_ROTWR: begin
          if (to_goal) goal_valid <= 1'b1;
          else meas_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_XMUL: state <= S_XACC;
        S_XACC: begin
          state <= S_XMUL;
          if (!term) begin
            term <= 1'b1;
          end else begin
            term <= 1'b0;
            if (comp != 2'd2) begin
              comp <= comp + 2'd1;
            end else begin
              comp <= '0;
              if (col != 2'd2) begin
                col <= col + 2'd1;
              end else begin
                state <= S_ERRWR;
              end
            end
          end
        end
        S_ERRWR: begin
          axis  <= '0;
          state <= S_AXSET;
        end
        S_AXSET: begin
          gterm <= '0;
          state <= S_GMUL;
        end
        S_GMUL: state <= S_GACC;
        S_GACC: begin
          if (gterm == 2'd2) begin
            state <= S_VOUT;
          end else begin
            gterm <= gterm + 2'd1;
            state <= S_GMUL;
          end
        end
        S_VOUT: begin
          if (axis == 3'd5) begin
            state <= S_PUB;
          end else begin
            axis  <= axis + 3'd1;
            state <= S_AXSET;
          end
        end
        S_PUB: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_wr_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_wr |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_rot_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.rot_wr |-> ($past(state) == S_QACC && $past(qidx) == 4'd8))
    else $error("rotation written before all products");

  a_out_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_en || cmd.ax_set) |-> !in_ready)
    else $error("request taken while busy");

endmodule
`default_nettype wire

FILE: design/cartesian_pose_pid_controller.sv
// Top level of the six-axis Cartesian pose PID controller.
// Depends on cppc_pkg, cppc_ctrl and cppc_datapath.
//
// Usage: requests arrive on in_valid/in_ready with op, frame_ok and a pose.
// op set target and feedback load a pose (position plus quaternion turned into
// a rotation matrix); abort clears the target and the PID history; tick, with
// both poses valid, produces one result of six velocities on out_valid/out_ready.
// Gains and limits are written on cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data; write them only while the block is idle.
// Sequencing: one request at a time, all multiplies on a single 33x33
// multiplier. A pose load forms nine quaternion products, then writes the
// rotation; a tick forms 18 cross products, then 3 products per axis, up to
// the result register. Abort and ignored requests leave the block idle.
// A result sits in the output register until taken; the next request is
// accepted meanwhile, and a following tick waits at its last step if the
// result is still untaken.
// Reset (synchronous, active high) restores gains, poses and PID state.
`default_nettype none
module cartesian_pose_pid_controller
  import cppc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic               frame_ok,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] rate_x,
  output logic signed [31:0] rate_y,
  output logic signed [31:0] rate_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  cppc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .frame_ok  (frame_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cppc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .rate_x    (rate_x),
    .rate_y    (rate_y),
    .rate_z    (rate_z)
  );

endmodule
`default_nettype wire
